[rtl/core/iac_pkg.sv]
package iac_pkg;

  localparam int DW    = 32;
  localparam int CNT_W = $clog2(DW);

  // operation codes
  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_POW = 5'd4;
  localparam logic [4:0] OP_REM = 5'd5;
  localparam logic [4:0] OP_AND = 5'd6;
  localparam logic [4:0] OP_OR  = 5'd7;
  localparam logic [4:0] OP_XOR = 5'd8;
  localparam logic [4:0] OP_SHR = 5'd9;
  localparam logic [4:0] OP_SHL = 5'd10;
  localparam logic [4:0] OP_LT  = 5'd11;
  localparam logic [4:0] OP_GT  = 5'd12;
  localparam logic [4:0] OP_GE  = 5'd13;
  localparam logic [4:0] OP_LE  = 5'd14;
  localparam logic [4:0] OP_EQ  = 5'd15;
  localparam logic [4:0] OP_NE  = 5'd16;
  localparam logic [4:0] OP_NZ  = 5'd17;

  // error codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_OP    = 3'd1;
  localparam logic [2:0] ERR_DIV0  = 3'd2;
  localparam logic [2:0] ERR_ZPOW  = 3'd3;
  localparam logic [2:0] ERR_SHIFT = 3'd4;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
  } div_res_t;

endpackage

[rtl/core/iac_mul.sv]
module iac_mul (
  input  logic                    clk,
  input  logic                    en,
  input  logic [iac_pkg::DW-1:0]  a,
  input  logic [iac_pkg::DW-1:0]  b,
  output logic [iac_pkg::DW-1:0]  prod
);

  logic [iac_pkg::DW-1:0] prod_r;

  // low half of the product is the same for signed and unsigned operands
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

[rtl/core/iac_div.sv]
module iac_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [iac_pkg::DW-1:0]  dividend,
  input  logic [iac_pkg::DW-1:0]  divisor,
  output iac_pkg::div_res_t       res
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [iac_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [iac_pkg::DW-1:0]     quo_r, quo_nxt;
  logic [iac_pkg::DW-1:0]     rem_r, rem_nxt;
  logic [iac_pkg::DW-1:0]     dvs_r, dvs_nxt;
  logic [iac_pkg::DW:0]       rem_sh;
  logic [iac_pkg::DW:0]       diff;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[iac_pkg::DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (diff[iac_pkg::DW]) begin
        rem_nxt = rem_sh[iac_pkg::DW-1:0];
        quo_nxt = {quo_r[iac_pkg::DW-2:0], 1'b0};
      end else begin
        rem_nxt = diff[iac_pkg::DW-1:0];
        quo_nxt = {quo_r[iac_pkg::DW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == iac_pkg::CNT_W'(iac_pkg::DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

[rtl/core/integer_alu_with_compare.sv]
// Add, sub, logic, shifts, compares, pow with a negative exponent and all error cases
// are computed at accept; mul uses the shared multiplier; div and rem use the shared
// divider, one quotient bit per cycle; pow with a nonnegative exponent steps through
// the exponent bits up to the highest set bit on the one shared multiplier.
// One item at a time: in_tready is high only while the sequencer is idle.
// Reset: rst_n synchronous active low, clears sequencer and output valid.
module integer_alu_with_compare (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // mode[4:0], operand_a[36:5], operand_b[68:37], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result[31:0], error_code[34:32], zero pad
);

  localparam int DW = iac_pkg::DW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_MULW  = 3'd2;
  localparam logic [2:0] S_PSTEP = 3'd3;
  localparam logic [2:0] S_PACCW = 3'd4;
  localparam logic [2:0] S_PSQW  = 3'd5;
  localparam logic [2:0] S_DIVW  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [4:0]           mode_r, mode_nxt;
  logic [DW-1:0]        opa_r, opa_nxt;
  logic [DW-1:0]        opb_r, opb_nxt;
  logic                 na_r, na_nxt;
  logic                 nb_r, nb_nxt;
  logic [DW-1:0]        acc_r, acc_nxt;
  logic [DW-1:0]        base_r, base_nxt;
  logic [DW-2:0]        exp_r, exp_nxt;
  logic [DW-1:0]        res_r, res_nxt;
  logic [2:0]           err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DW-1:0]        out_res_r, out_res_nxt;
  logic [2:0]           out_err_r, out_err_nxt;

  logic [4:0]           f_mode;
  logic signed [DW-1:0] f_a;
  logic signed [DW-1:0] f_b;
  logic                 accept;
  logic                 shift_bad;
  logic [DW-1:0]        mag_a;
  logic [DW-1:0]        mag_b;
  logic                 div_start;
  logic                 mul_en;
  logic [DW-1:0]        mul_a;
  logic [DW-1:0]        mul_b;
  logic [DW-1:0]        mul_p;
  iac_pkg::div_res_t    div_res;

  assign f_mode = in_tdata[4:0];
  assign f_a    = in_tdata[36:5];
  assign f_b    = in_tdata[68:37];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign shift_bad = f_b[DW-1] || (|f_b[DW-1:iac_pkg::CNT_W]);
  assign mag_a     = f_a[DW-1] ? (~f_a + 1'b1) : f_a;
  assign mag_b     = f_b[DW-1] ? (~f_b + 1'b1) : f_b;

  iac_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  iac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .res      (div_res)
  );

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = opa_r;
    mul_b  = opb_r;
    unique case (state_r)
      S_MUL: begin
        mul_en = 1'b1;
      end
      S_PSTEP: begin
        mul_en = 1'b1;
        if (exp_r[0]) begin
          mul_a = acc_r;
          mul_b = base_r;
        end else begin
          mul_a = base_r;
          mul_b = base_r;
        end
      end
      S_PACCW: begin
        mul_en = 1'b1;
        mul_a  = base_r;
        mul_b  = base_r;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt  = f_mode;
          opa_nxt   = f_a;
          opb_nxt   = f_b;
          na_nxt    = f_a[DW-1];
          nb_nxt    = f_b[DW-1];
          res_nxt   = '0;
          err_nxt   = iac_pkg::ERR_OK;
          state_nxt = S_DONE;
          unique case (f_mode) inside
            iac_pkg::OP_ADD: res_nxt = f_a + f_b;
            iac_pkg::OP_SUB: res_nxt = f_a - f_b;
            iac_pkg::OP_MUL: state_nxt = S_MUL;
            iac_pkg::OP_DIV, iac_pkg::OP_REM: begin
              if (f_b == '0) begin
                err_nxt = iac_pkg::ERR_DIV0;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIVW;
              end
            end
            iac_pkg::OP_POW: begin
              if (f_b[DW-1]) begin
                // negative exponent: only bases 0, 1 and -1 are special
                if (f_a == '0) begin
                  err_nxt = iac_pkg::ERR_ZPOW;
                end else if (f_a == DW'(1)) begin
                  res_nxt = DW'(1);
                end else if (&f_a) begin
                  res_nxt = f_b[0] ? '1 : DW'(1);
                end
              end else begin
                acc_nxt   = DW'(1);
                base_nxt  = f_a;
                exp_nxt   = f_b[DW-2:0];
                state_nxt = S_PSTEP;
              end
            end
            iac_pkg::OP_AND: res_nxt = f_a & f_b;
            iac_pkg::OP_OR:  res_nxt = f_a | f_b;
            iac_pkg::OP_XOR: res_nxt = f_a ^ f_b;
            iac_pkg::OP_SHR: begin
              if (shift_bad) err_nxt = iac_pkg::ERR_SHIFT;
              else           res_nxt = f_a >>> f_b[iac_pkg::CNT_W-1:0];
            end
            iac_pkg::OP_SHL: begin
              if (shift_bad) err_nxt = iac_pkg::ERR_SHIFT;
              else           res_nxt = f_a << f_b[iac_pkg::CNT_W-1:0];
            end
            iac_pkg::OP_LT: res_nxt = DW'(f_a < f_b);
            iac_pkg::OP_GT: res_nxt = DW'(f_b < f_a);
            iac_pkg::OP_GE: res_nxt = DW'(!(f_a < f_b));
            iac_pkg::OP_LE: res_nxt = DW'(!(f_b < f_a));
            iac_pkg::OP_EQ: res_nxt = DW'(f_a == f_b);
            iac_pkg::OP_NE: res_nxt = DW'(f_a != f_b);
            iac_pkg::OP_NZ: res_nxt = DW'(f_a != '0);
            default:        err_nxt = iac_pkg::ERR_OP;
          endcase
        end
      end
      S_MUL: begin
        state_nxt = S_MULW;
      end
      S_MULW: begin
        res_nxt   = mul_p;
        state_nxt = S_DONE;
      end
      S_PSTEP: begin
        if (exp_r == '0) begin
          res_nxt   = acc_r;
          state_nxt = S_DONE;
        end else if (exp_r[0]) begin
          state_nxt = S_PACCW;
        end else begin
          state_nxt = S_PSQW;
        end
      end
      S_PACCW: begin
        acc_nxt   = mul_p;
        state_nxt = S_PSQW;
      end
      S_PSQW: begin
        base_nxt  = mul_p;
        exp_nxt   = exp_r >> 1;
        state_nxt = S_PSTEP;
      end
      S_DIVW: begin
        if (div_res.done) begin
          if (mode_r == iac_pkg::OP_REM) begin
            res_nxt = na_r ? (~div_res.rem + 1'b1) : div_res.rem;
          end else begin
            res_nxt = (na_r ^ nb_r) ? (~div_res.quo + 1'b1) : div_res.quo;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    opa_r     <= opa_nxt;
    opb_r     <= opb_nxt;
    na_r      <= na_nxt;
    nb_r      <= nb_nxt;
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    exp_r     <= exp_nxt;
    res_r     <= res_nxt;
    err_r     <= err_nxt;
    out_res_r <= out_res_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_err_r, out_res_r};

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_err_r == iac_pkg::ERR_OK || out_err_r == iac_pkg::ERR_OP ||
                    out_err_r == iac_pkg::ERR_DIV0 || out_err_r == iac_pkg::ERR_ZPOW ||
                    out_err_r == iac_pkg::ERR_SHIFT))
    else $error("bad error code on result beat");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_err_r != iac_pkg::ERR_OK) |-> (out_res_r == '0))
    else $error("nonzero result with error");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted beat while busy");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIVW))
    else $error("divider finished outside divide wait");

endmodule

[tb/sv/integer_alu_with_compare_test.sv]
`timescale 1ns / 100ps

module integer_alu_with_compare_test;

  localparam int N_ITEMS     = 1550;
  localparam int TAIL_ITEMS  = 120;      // last items go with no idling on either side
  localparam int HOLD_AFTER  = 300;      // results seen before the long output hold
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 150;      // wait after all results are checked, before the verdict
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_op_t;

  typedef struct packed {
    alu_op_t     item;
    logic [31:0] value;
    logic [2:0]  err;
  } alu_expect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  alu_op_t     pending_ops[$];
  alu_expect_t expected_results[$];
  logic        in_taken = 1'b0;
  int          in_gap = 0;
  int          rcv_gap = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          cycle_count;

  integer_alu_with_compare dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic alu_expect_t alu_predict(alu_op_t it);
    alu_expect_t       r;
    logic signed [31:0] a;
    logic signed [31:0] b;
    longint            la;
    longint            lb;
    logic [31:0]       acc;
    logic [31:0]       base;
    a = it.a;
    b = it.b;
    la = a;
    lb = b;
    r.item = it;
    r.value = '0;
    r.err = iac_pkg::ERR_OK;
    case (it.op) inside
      iac_pkg::OP_ADD: r.value = a + b;
      iac_pkg::OP_SUB: r.value = a - b;
      iac_pkg::OP_MUL: r.value = a * b;
      iac_pkg::OP_DIV, iac_pkg::OP_REM: begin
        // 64-bit math keeps min / -1 from trapping; truncation toward zero
        if (b == 0) r.err = iac_pkg::ERR_DIV0;
        else if (it.op == iac_pkg::OP_DIV) r.value = 32'(la / lb);
        else r.value = 32'(la % lb);
      end
      iac_pkg::OP_POW: begin
        if (b < 0) begin
          if (a == 0) r.err = iac_pkg::ERR_ZPOW;
          else if (a == 1) r.value = 32'd1;
          else if (a == -1) r.value = b[0] ? 32'hffff_ffff : 32'd1;
        end else begin
          acc = 32'd1;
          base = a;
          for (int i = 0; i < 32; i++) begin
            if (b[i]) acc = acc * base;
            base = base * base;
          end
          r.value = acc;
        end
      end
      iac_pkg::OP_AND: r.value = a & b;
      iac_pkg::OP_OR:  r.value = a | b;
      iac_pkg::OP_XOR: r.value = a ^ b;
      iac_pkg::OP_SHR, iac_pkg::OP_SHL: begin
        if (b < 0 || b > 31) r.err = iac_pkg::ERR_SHIFT;
        else if (it.op == iac_pkg::OP_SHR) r.value = a >>> b[4:0];
        else r.value = a << b[4:0];
      end
      iac_pkg::OP_LT: r.value = {31'b0, a < b};
      iac_pkg::OP_GT: r.value = {31'b0, a > b};
      iac_pkg::OP_GE: r.value = {31'b0, a >= b};
      iac_pkg::OP_LE: r.value = {31'b0, a <= b};
      iac_pkg::OP_EQ: r.value = {31'b0, a == b};
      iac_pkg::OP_NE: r.value = {31'b0, a != b};
      iac_pkg::OP_NZ: r.value = {31'b0, a != 0};
      default: r.err = iac_pkg::ERR_OP;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic add_op(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b);
    alu_op_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    pending_ops.push_back(it);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return 32'($urandom_range(0, 32)) - 32'd16;
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom() >> $urandom_range(1, 31);
    endcase
  endfunction

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return pick_operand();
      1, 2: return -32'($urandom_range(1, 9));
      default: return 32'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [31:0] pick_shift();
    if ($urandom_range(0, 5) == 0) return pick_operand();
    return 32'($urandom_range(0, 31));
  endfunction

  // stimulus and end of run
  initial begin : main
    logic [4:0]  op;
    logic [31:0] b;
    add_op(iac_pkg::OP_ADD, 32'h7fff_ffff, 32'd1);
    add_op(iac_pkg::OP_SUB, 32'h8000_0000, 32'd1);
    add_op(iac_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(iac_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    add_op(iac_pkg::OP_REM, 32'h8000_0000, 32'hffff_ffff);
    add_op(iac_pkg::OP_DIV, -32'd7, 32'd2);
    add_op(iac_pkg::OP_REM, -32'd7, 32'd2);
    add_op(iac_pkg::OP_DIV, 32'd1234, 32'd0);
    add_op(iac_pkg::OP_REM, 32'hffff_ffff, 32'd0);
    add_op(iac_pkg::OP_POW, 32'd0, 32'hffff_ffff);
    add_op(iac_pkg::OP_POW, 32'd1, -32'd5);
    add_op(iac_pkg::OP_POW, 32'hffff_ffff, -32'd3);
    add_op(iac_pkg::OP_POW, 32'hffff_ffff, -32'd4);
    add_op(iac_pkg::OP_POW, 32'd2, 32'hffff_ffff);
    add_op(iac_pkg::OP_POW, 32'd0, 32'd0);
    add_op(iac_pkg::OP_POW, 32'd3, 32'h7fff_ffff);
    add_op(iac_pkg::OP_AND, 32'hf0f0_a5a5, 32'hffff_0000);
    add_op(iac_pkg::OP_OR,  32'h8000_0000, 32'h7fff_ffff);
    add_op(iac_pkg::OP_XOR, 32'haaaa_5555, 32'hffff_ffff);
    add_op(iac_pkg::OP_SHR, 32'h8000_0000, 32'd31);
    add_op(iac_pkg::OP_SHR, 32'h1234_5678, 32'd32);
    add_op(iac_pkg::OP_SHL, 32'd1, 32'd31);
    add_op(iac_pkg::OP_SHL, 32'd1, 32'hffff_ffff);
    add_op(iac_pkg::OP_LT,  32'h8000_0000, 32'h7fff_ffff);
    add_op(iac_pkg::OP_GT,  32'h8000_0000, 32'h7fff_ffff);
    add_op(iac_pkg::OP_GE,  32'hffff_ffff, 32'hffff_ffff);
    add_op(iac_pkg::OP_LE,  32'h7fff_ffff, 32'h8000_0000);
    add_op(iac_pkg::OP_EQ,  32'h8000_0000, 32'h8000_0000);
    add_op(iac_pkg::OP_NE,  32'd0, 32'd0);
    add_op(iac_pkg::OP_NZ,  32'd0, 32'd5);
    add_op(5'd31,  32'd3, 32'd4);

    while (pending_ops.size() < N_ITEMS) begin
      if ($urandom_range(0, 15) == 0) op = 5'($urandom_range(18, 31));
      else op = 5'($urandom_range(0, 17));
      case (op) inside
        iac_pkg::OP_POW:                  b = pick_exponent();
        iac_pkg::OP_SHR, iac_pkg::OP_SHL: b = pick_shift();
        default:                          b = pick_operand();
      endcase
      add_op(op, pick_operand(), b);
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // input driver: a new beat goes out once the last one was taken
  always @(negedge clk) begin : driver
    alu_op_t nxt;
    if (rst_n && (in_taken || !in_tvalid)) begin
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (in_taken && pending_ops.size() >= TAIL_ITEMS
                   && $urandom_range(0, 6) == 0) begin
        in_gap = $urandom_range(0, 17);
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        nxt = pending_ops.pop_front();
        in_tdata <= {3'b000, nxt.b, nxt.a, nxt.op};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready: random bursts, one long hold to back the block up
  always @(negedge clk) begin : receiver
    bit rdy;
    if (rst_n) begin
      rdy = 1'b1;
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
        rdy = 1'b0;
      end else if (rcv_gap != 0) begin
        rcv_gap--;
        rdy = 1'b0;
      end else if (pending_ops.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        rcv_gap = $urandom_range(0, 17);
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // predict on input beats, check on output beats
  always @(posedge clk) begin : scoreboard
    alu_op_t     seen;
    alu_expect_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      seen.op = in_tdata[4:0];
      seen.a  = in_tdata[36:5];
      seen.b  = in_tdata[68:37];
      expected_results.push_back(alu_predict(seen));
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing outstanding", out_tdata));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.value)
          report_mismatch($sformatf("op %0d a %h b %h: result %h, want %h",
            want.item.op, want.item.a, want.item.b, out_tdata[31:0], want.value));
        if (out_tdata[34:32] !== want.err)
          report_mismatch($sformatf("op %0d a %h b %h: error %0d, want %0d",
            want.item.op, want.item.a, want.item.b, out_tdata[34:32], want.err));
      end
    end
  end

endmodule
